>>> src/idm_pkg.sv
`timescale 1ns / 1ps
// Package for the inline delimiter matcher: sizes, status and event codes,
// stack entry, cell control, cell status and result types. Depends on nothing.
package idm_pkg;

    localparam int DEPTH    = 32;
    localparam int POS_BITS = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_PUSHED    = 3'd0,
        ST_MATCHED   = 3'd1,
        ST_DISCARDED = 3'd2,
        ST_IGNORED   = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_COMMENT   = 3'd5,
        ST_ENTRY     = 3'd6,
        ST_EMPTY     = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_ENTER = 2'd1,
        EV_EXIT  = 2'd2
    } event_t;

    typedef struct packed {
        logic [3:0]          etype;
        logic                opens;
        logic [POS_BITS-1:0] pos;
        logic [POS_BITS-1:0] len;
        event_t              ev;
    } entry_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic [3:0]       tok_type;
        logic             probe_load;
        logic             probe_down;
        logic             probe_up;
        logic [IDX_W-1:0] probe_ptr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_ptr;
        entry_t           wr_entry;
        logic             mark_en;
        logic             shift_en;
    } cell_ctrl_t;

    // What a cell reports while the probe sits on it.
    typedef struct packed {
        logic hit;
        logic stop;
        logic marked;
    } cell_stat_t;

    typedef struct packed {
        status_t             status;
        logic [CNT_W-1:0]    slot;
        logic [CNT_W-1:0]    partner;
        logic [3:0]          etype;
        logic [POS_BITS-1:0] pos;
        logic [POS_BITS-1:0] len;
        event_t              ev;
        logic                last;
    } result_t;

endpackage

>>> src/idm_cell.sv
`timescale 1ns / 1ps
// One stack slot of the matcher chain: holds an entry and the probe bit.
// Depends on idm_pkg.
module idm_cell
    import idm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] cell_idx,
    input  cell_ctrl_t       ctrl,
    input  entry_t           entry_above,
    input  logic             probe_above,
    input  logic             probe_below,
    output entry_t           entry,
    output logic             probe,
    output cell_stat_t       stat
);

    entry_t entry_reg, entry_next;
    logic   probe_reg, probe_next;

    always_comb
    begin
        if (ctrl.probe_load)
            probe_next = (cell_idx == ctrl.probe_ptr);
        else if (ctrl.probe_down)
            probe_next = probe_above;
        else if (ctrl.probe_up)
            probe_next = probe_below;
        else
            probe_next = probe_reg;
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift_en)
            entry_next = entry_above;
        else if (ctrl.wr_en && cell_idx == ctrl.wr_ptr)
            entry_next = ctrl.wr_entry;
        else if (ctrl.mark_en && probe_reg)
            entry_next.ev = EV_ENTER;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            probe_reg <= 1'b0;
        else
            probe_reg <= probe_next;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry       = entry_reg;
    assign probe       = probe_reg;
    assign stat.hit    = probe_reg && entry_reg.etype == ctrl.tok_type && entry_reg.opens
                         && entry_reg.ev == EV_NONE;
    assign stat.stop   = probe_reg && entry_reg.etype > ctrl.tok_type;
    assign stat.marked = probe_reg && entry_reg.ev != EV_NONE;

endmodule

>>> src/inline_delimiter_matcher.sv
`timescale 1ns / 1ps
// Top level of the inline delimiter matcher: controller and the cell chain.
// Depends on idm_pkg and idm_cell.
//
// Usage: tokens of one markup line arrive on the input channel (in_valid,
// in_stall), one transfer per token; a transfer with action set flushes the
// line. Each token gives one result transfer on the output channel
// (out_valid, out_stall); a flush gives one result per stack entry, bottom
// to top, or one empty result, with last set on the final one.
// The stack is a chain of DEPTH cells. A search probe steps one cell per
// cycle from the top of the stack down to the lower bound, and after a
// match at the lower bound it steps back up one cell per cycle.
// A token is dispatched, searched and, if the lower bound moves,
// advanced; then its result enters the output register. A comment writes
// its enter and exit entries in turn. A flush shifts the chain down one
// cell per result, one result per cycle while out_stall is low. One item
// is processed at a time; in_stall is high while an item is in progress.
// Reset empties the stack and clears the comment flag; no clearing pass.
// While the receiver holds out_stall, the result stays in the output
// register and the block waits before producing the next one.
module inline_delimiter_matcher
    import idm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                action,
    input  logic [3:0]          token_type,
    input  logic                opens,
    input  logic [POS_BITS-1:0] start_pos,
    input  logic [POS_BITS-1:0] span_len,
    input  logic                is_comment,
    input  logic [POS_BITS-1:0] line_end,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          status,
    output logic [CNT_W-1:0]    slot,
    output logic [CNT_W-1:0]    partner_slot,
    output logic [3:0]          entry_type,
    output logic [POS_BITS-1:0] entry_pos,
    output logic [POS_BITS-1:0] entry_len,
    output logic [1:0]          entry_event,
    output logic                last
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISPATCH = 7'b0000010,
        S_CMT2     = 7'b0000100,
        S_SEARCH   = 7'b0001000,
        S_ADVANCE  = 7'b0010000,
        S_DONE     = 7'b0100000,
        S_FLUSH    = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    lb_reg, lb_next;
    logic                cmt_reg, cmt_next;
    logic [IDX_W-1:0]    srch_reg, srch_next;
    logic [CNT_W-1:0]    rd_reg, rd_next;
    result_t             res_reg, res_next;
    result_t             out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic                tok_action_reg, tok_opens_reg, tok_cmt_reg;
    logic [3:0]          tok_type_reg;
    logic [POS_BITS-1:0] tok_pos_reg, tok_len_reg, tok_end_reg;

    cell_ctrl_t          ctrl;
    entry_t              entry_q [DEPTH];
    logic [DEPTH-1:0]    probe_q;
    cell_stat_t          stat_q [DEPTH];
    logic [DEPTH-1:0]    hit_v, stop_v, marked_v;

    logic                accept, out_free, out_load, do_nomatch, flush_last;
    logic                any_hit, any_stop, any_marked;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            entry_t above_e;
            logic   above_p, below_p;
            if (g == DEPTH - 1)
            begin : g_top
                assign above_e = '0;
                assign above_p = 1'b0;
            end
            else
            begin : g_mid
                assign above_e = entry_q[g+1];
                assign above_p = probe_q[g+1];
            end
            if (g == 0)
            begin : g_bot
                assign below_p = 1'b0;
            end
            else
            begin : g_up
                assign below_p = probe_q[g-1];
            end
            idm_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cell_idx    (IDX_W'(g)),
                .ctrl        (ctrl),
                .entry_above (above_e),
                .probe_above (above_p),
                .probe_below (below_p),
                .entry       (entry_q[g]),
                .probe       (probe_q[g]),
                .stat        (stat_q[g])
            );
            assign hit_v[g]    = stat_q[g].hit;
            assign stop_v[g]   = stat_q[g].stop;
            assign marked_v[g] = stat_q[g].marked;
        end
    endgenerate

    assign any_hit    = |hit_v;
    assign any_stop   = |stop_v;
    assign any_marked = |marked_v;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    function automatic result_t tok_res(input status_t st, input logic [3:0] t,
                                        input logic [POS_BITS-1:0] p,
                                        input logic [POS_BITS-1:0] l);
        result_t r;
        r         = '0;
        r.status  = st;
        r.etype   = t;
        r.pos     = p;
        r.len     = l;
        r.ev      = EV_NONE;
        return r;
    endfunction

    // Index of the top entry of a non-empty stack.
    function automatic logic [IDX_W-1:0] count_next_idx(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] t;
        t = c - CNT_W'(1);
        return t[IDX_W-1:0];
    endfunction

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        lb_next        = lb_reg;
        cmt_next       = cmt_reg;
        srch_next      = srch_reg;
        rd_next        = rd_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_load       = 1'b0;
        do_nomatch     = 1'b0;
        flush_last     = 1'b0;
        ctrl           = '0;
        ctrl.tok_type  = tok_type_reg;
        ctrl.wr_ptr    = count_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                if (tok_action_reg)
                begin
                    if (count_reg == '0)
                    begin
                        res_next        = '0;
                        res_next.status = ST_EMPTY;
                        res_next.ev     = EV_NONE;
                        res_next.last   = 1'b1;
                        lb_next         = '0;
                        cmt_next        = 1'b0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        rd_next    = '0;
                        state_next = S_FLUSH;
                    end
                end
                else if (cmt_reg)
                begin
                    res_next   = tok_res(ST_IGNORED, tok_type_reg, tok_pos_reg, tok_len_reg);
                    state_next = S_DONE;
                end
                else if (tok_cmt_reg)
                begin
                    if (count_reg > CNT_W'(DEPTH - 2))
                    begin
                        res_next   = tok_res(ST_OVERFLOW, tok_type_reg, tok_pos_reg,
                                             tok_len_reg);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ctrl.wr_en          = 1'b1;
                        ctrl.wr_entry.etype = tok_type_reg;
                        ctrl.wr_entry.opens = tok_opens_reg;
                        ctrl.wr_entry.pos   = tok_pos_reg;
                        ctrl.wr_entry.len   = tok_len_reg;
                        ctrl.wr_entry.ev    = EV_ENTER;
                        res_next            = tok_res(ST_COMMENT, tok_type_reg, tok_pos_reg,
                                                      tok_len_reg);
                        res_next.ev         = EV_ENTER;
                        res_next.slot       = count_reg;
                        res_next.partner    = count_reg + CNT_W'(1);
                        count_next          = count_reg + CNT_W'(1);
                        state_next          = S_CMT2;
                    end
                end
                else if (count_reg > lb_reg)
                begin
                    ctrl.probe_load = 1'b1;
                    ctrl.probe_ptr  = count_next_idx(count_reg);
                    srch_next       = count_next_idx(count_reg);
                    state_next      = S_SEARCH;
                end
                else
                begin
                    do_nomatch = 1'b1;
                end
            end
            S_CMT2:
            begin
                ctrl.wr_en          = 1'b1;
                ctrl.wr_entry.etype = tok_type_reg;
                ctrl.wr_entry.opens = 1'b0;
                ctrl.wr_entry.pos   = tok_end_reg;
                ctrl.wr_entry.len   = '0;
                ctrl.wr_entry.ev    = EV_EXIT;
                count_next          = count_reg + CNT_W'(1);
                cmt_next            = 1'b1;
                state_next          = S_DONE;
            end
            S_SEARCH:
            begin
                if (any_hit)
                begin
                    if (count_reg >= CNT_W'(DEPTH))
                    begin
                        res_next   = tok_res(ST_OVERFLOW, tok_type_reg, tok_pos_reg,
                                             tok_len_reg);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ctrl.mark_en        = 1'b1;
                        ctrl.wr_en          = 1'b1;
                        ctrl.wr_entry.etype = tok_type_reg;
                        ctrl.wr_entry.opens = tok_opens_reg;
                        ctrl.wr_entry.pos   = tok_pos_reg;
                        ctrl.wr_entry.len   = tok_len_reg;
                        ctrl.wr_entry.ev    = EV_EXIT;
                        res_next            = tok_res(ST_MATCHED, tok_type_reg, tok_pos_reg,
                                                      tok_len_reg);
                        res_next.ev         = EV_EXIT;
                        res_next.slot       = count_reg;
                        res_next.partner    = CNT_W'(srch_reg);
                        count_next          = count_reg + CNT_W'(1);
                        // The probe stays on the opener; at the lower bound it walks up from there.
                        if (CNT_W'(srch_reg) == lb_reg)
                            state_next = S_ADVANCE;
                        else
                            state_next = S_DONE;
                    end
                end
                else if (any_stop || CNT_W'(srch_reg) == lb_reg)
                begin
                    do_nomatch = 1'b1;
                end
                else
                begin
                    srch_next       = srch_reg - IDX_W'(1);
                    ctrl.probe_down = 1'b1;
                end
            end
            S_ADVANCE:
            begin
                if (lb_reg < count_reg && any_marked)
                begin
                    lb_next       = lb_reg + CNT_W'(1);
                    ctrl.probe_up = 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next   = res_reg;
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    flush_last       = (rd_reg + CNT_W'(1) == count_reg);
                    out_next         = '0;
                    out_next.status  = ST_ENTRY;
                    out_next.slot    = rd_reg;
                    out_next.etype   = entry_q[0].etype;
                    out_next.pos     = entry_q[0].pos;
                    out_next.len     = entry_q[0].len;
                    out_next.ev      = entry_q[0].ev;
                    out_next.last    = flush_last;
                    out_load         = 1'b1;
                    ctrl.shift_en    = 1'b1;
                    rd_next          = rd_reg + CNT_W'(1);
                    if (flush_last)
                    begin
                        count_next = '0;
                        lb_next    = '0;
                        cmt_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_nomatch)
        begin
            state_next = S_DONE;
            if (tok_opens_reg)
            begin
                if (count_reg >= CNT_W'(DEPTH))
                begin
                    res_next = tok_res(ST_OVERFLOW, tok_type_reg, tok_pos_reg, tok_len_reg);
                end
                else
                begin
                    ctrl.wr_en          = 1'b1;
                    ctrl.wr_entry.etype = tok_type_reg;
                    ctrl.wr_entry.opens = 1'b1;
                    ctrl.wr_entry.pos   = tok_pos_reg;
                    ctrl.wr_entry.len   = tok_len_reg;
                    ctrl.wr_entry.ev    = EV_NONE;
                    res_next            = tok_res(ST_PUSHED, tok_type_reg, tok_pos_reg,
                                                  tok_len_reg);
                    res_next.slot       = count_reg;
                    count_next          = count_reg + CNT_W'(1);
                end
            end
            else
            begin
                res_next = tok_res(ST_DISCARDED, tok_type_reg, tok_pos_reg, tok_len_reg);
            end
        end

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            lb_reg        <= '0;
            cmt_reg       <= 1'b0;
            srch_reg      <= '0;
            rd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            lb_reg        <= lb_next;
            cmt_reg       <= cmt_next;
            srch_reg      <= srch_next;
            rd_reg        <= rd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        out_reg <= out_next;
        if (accept)
        begin
            tok_action_reg <= action;
            tok_type_reg   <= token_type;
            tok_opens_reg  <= opens;
            tok_pos_reg    <= start_pos;
            tok_len_reg    <= span_len;
            tok_cmt_reg    <= is_comment;
            tok_end_reg    <= line_end;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign slot         = out_reg.slot;
    assign partner_slot = out_reg.partner;
    assign entry_type   = out_reg.etype;
    assign entry_pos    = out_reg.pos;
    assign entry_len    = out_reg.len;
    assign entry_event  = out_reg.ev;
    assign last         = out_reg.last;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("stack count beyond depth");

    a_lb_range: assert property (@(posedge clk) disable iff (!rst_n)
        lb_reg <= count_reg)
        else $error("lower bound above stack top");

    a_probe_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(probe_q))
        else $error("more than one cell holds the probe");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH && flush_last) |=> (count_reg == '0 && lb_reg == '0))
        else $error("flush did not empty the stack");
`endif

endmodule
